/* src/cascaded_biquad_equalizer_macros.svh */
// assertion macros for the cascaded biquad equalizer
// used by the top level only, no other dependencies
`ifndef CASCADED_BIQUAD_EQUALIZER_MACROS_SVH
`define CASCADED_BIQUAD_EQUALIZER_MACROS_SVH

// same-cycle implication
`define CBQ_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/cbq_pkg.sv */
// shared constants, codes and types of the cascaded biquad equalizer
// no dependencies
package cbq_pkg;

   localparam int MAX_BANDS   = 8;
   localparam int SAMPLE_W    = 24;
   localparam int COEFF_W     = 32;
   localparam int DELAY_W     = 40;
   localparam int DELAY_FRAC  = 8;
   localparam int COEFF_FRAC  = 24;
   localparam int PROD_SHIFT  = COEFF_FRAC - DELAY_FRAC;
   localparam int NUM_COEFFS  = 5;
   localparam int NUM_ENTRIES = MAX_BANDS * NUM_COEFFS;
   localparam int CIDX_W      = $clog2(NUM_ENTRIES);
   localparam int BAND_W      = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int BCNT_W      = $clog2(MAX_BANDS + 1);
   localparam int SEL_W       = 3;
   localparam int BSEL_W      = 3;
   localparam int CVAL_W      = 32;
   localparam int MUL_W       = COEFF_W + SAMPLE_W;
   localparam int MPROD_W     = MUL_W - PROD_SHIFT;
   localparam int SUM_W       = DELAY_W + 2;
   localparam int SHR_W       = SUM_W - DELAY_FRAC;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 4;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_COEFF  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_BAND_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE     = 1'b1;

   localparam logic [SEL_W-1:0] CSEL_B0 = 3'd0;
   localparam logic [SEL_W-1:0] CSEL_B1 = 3'd1;
   localparam logic [SEL_W-1:0] CSEL_B2 = 3'd2;
   localparam logic [SEL_W-1:0] CSEL_A1 = 3'd3;
   localparam logic [SEL_W-1:0] CSEL_A2 = 3'd4;

   typedef struct packed {
      logic                      en;
      logic [CIDX_W-1:0]         addr;
      logic signed [COEFF_W-1:0] data;
   } cbq_coeff_wr_type;

endpackage

/* src/cbq_coeff_store.sv */
// coefficient store: one write port, one registered read port
// per-entry valid bits make unwritten entries read as zero; uses cbq_pkg
module cbq_coeff_store
   import cbq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cbq_coeff_wr_type          wr,
   input  logic [CIDX_W-1:0]         rd_addr,
   output logic signed [COEFF_W-1:0] rd_data
);

   logic signed [COEFF_W-1:0] mem_ff [0:NUM_ENTRIES-1];
   logic [NUM_ENTRIES-1:0]    vld_ff;
   logic signed [COEFF_W-1:0] rd_ff;
   logic                      rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

/* src/cascaded_biquad_equalizer.sv */
// top level of the cascaded biquad equalizer: sequencer, shared multiplier, delay words
// uses cbq_pkg, cbq_coeff_store and cascaded_biquad_equalizer_macros.svh
//
//   channel | ports                     | beat
//   req     | req_valid / req_ready     | sample or coefficient write
//   rsp     | rsp_valid / rsp_ready     | filtered or bypassed sample
//   csr     | csr_valid / csr_ready     | register index and data
//
// filtered sample: the bands run one after another on the one shared 32x24 multiplier
// bypassed sample and coefficient write: handled straight from idle, without the multiplier
// reset clears delay words and coefficient valid bits, sets one band and enable; no clearing pass
// a waiting result holds req_ready low until rsp takes it; csr is always ready
`include "cascaded_biquad_equalizer_macros.svh"

module cascaded_biquad_equalizer
   import cbq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   input  logic                       req_block_end,
   input  logic [BSEL_W-1:0]          req_band_sel,
   input  logic [SEL_W-1:0]           req_coeff_sel,
   input  logic signed [CVAL_W-1:0]   req_coeff_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_block_end_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [2:0] PH_MB0 = 3'd0;
   localparam logic [2:0] PH_MB1 = 3'd1;
   localparam logic [2:0] PH_MA1 = 3'd2;
   localparam logic [2:0] PH_MB2 = 3'd3;
   localparam logic [2:0] PH_MA2 = 3'd4;
   localparam logic [2:0] PH_Z2  = 3'd5;

   localparam logic signed [SUM_W-1:0] RND = SUM_W'(2 ** (DELAY_FRAC - 1));

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SHR_W-1:0] v);
      if ((&v[SHR_W-1:SAMPLE_W-1]) || !(|v[SHR_W-1:SAMPLE_W-1])) begin
         return v[SAMPLE_W-1:0];
      end else if (v[SHR_W-1]) begin
         return {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [DELAY_W-1:0] sat_delay(
      input logic signed [SUM_W-1:0] v);
      if ((&v[SUM_W-1:DELAY_W-1]) || !(|v[SUM_W-1:DELAY_W-1])) begin
         return v[DELAY_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(DELAY_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DELAY_W-1){1'b1}}};
      end
   endfunction

   // control
   logic [1:0]           state_ff, state_in;
   logic [2:0]           phase_ff, phase_in;
   logic [BAND_W-1:0]    band_ff, band_in;
   logic [BCNT_W-1:0]    band_count_ff, band_count_in;
   logic                 enable_ff, enable_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] y_ff, y_in;
   logic signed [SUM_W-1:0]    acc_ff, acc_in;
   logic signed [MPROD_W-1:0]  prod_ff, prod_in;
   logic                       blk_ff, blk_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                       rsp_blk_ff, rsp_blk_in;
   logic signed [DELAY_W-1:0]  z1_ff [0:MAX_BANDS-1];
   logic signed [DELAY_W-1:0]  z1_in [0:MAX_BANDS-1];
   logic signed [DELAY_W-1:0]  z2_ff [0:MAX_BANDS-1];
   logic signed [DELAY_W-1:0]  z2_in [0:MAX_BANDS-1];

   logic                       req_acc, out_free, csr_acc, use_y;
   logic [BAND_W-1:0]          rd_band;
   logic [SEL_W-1:0]           rd_sel;
   logic [CIDX_W-1:0]          rd_addr;
   logic signed [COEFF_W-1:0]  coef;
   logic signed [SAMPLE_W-1:0] mul_x;
   logic signed [MUL_W-1:0]    mul_full;
   logic signed [SUM_W-1:0]    ysum;
   logic [CSR_DATA_W-1:0]      n_req;
   cbq_coeff_wr_type           wr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_acc   = csr_valid && csr_ready;
   assign n_req     = csr_data;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_block_end_out = rsp_blk_ff;

   // coefficient prefetch: the read in one phase feeds the multiply of the next
   always_comb begin
      rd_band = band_ff;
      rd_sel  = CSEL_B0;
      if (state_ff == ST_RUN) begin
         case (phase_ff)
            PH_MB0:  rd_sel = CSEL_B1;
            PH_MB1:  rd_sel = CSEL_A1;
            PH_MA1:  rd_sel = CSEL_B2;
            PH_MB2:  rd_sel = CSEL_A2;
            PH_Z2:   rd_band = band_ff + 1'b1;
            default: rd_sel = CSEL_B0;
         endcase
      end else begin
         rd_band = '0;
      end
   end

   assign rd_addr = CIDX_W'(rd_band) * CIDX_W'(NUM_COEFFS) + CIDX_W'(rd_sel);

   always_comb begin
      wr.en   = req_acc && (req_func == FUNC_COEFF)
                && (int'(req_band_sel) < MAX_BANDS)
                && (int'(req_coeff_sel) < NUM_COEFFS);
      wr.addr = CIDX_W'(req_band_sel) * CIDX_W'(NUM_COEFFS) + CIDX_W'(req_coeff_sel);
      wr.data = COEFF_W'(req_coeff_value);
   end

   cbq_coeff_store u_coeff (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (coef)
   );

   // shared multiplier
   assign use_y    = (state_ff == ST_RUN) && ((phase_ff == PH_MA1) || (phase_ff == PH_MA2));
   assign mul_x    = use_y ? y_ff : x_ff;
   assign mul_full = MUL_W'(coef) * MUL_W'(mul_x);
   assign prod_in  = mul_full[MUL_W-1:PROD_SHIFT];

   assign ysum = SUM_W'(prod_ff) + SUM_W'(z1_ff[band_ff]) + RND;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      band_in       = band_ff;
      band_count_in = band_count_ff;
      enable_in     = enable_ff;
      rsp_valid_in  = rsp_valid_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      blk_in        = blk_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_blk_in    = rsp_blk_ff;
      z1_in         = z1_ff;
      z2_in         = z2_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_acc) begin
         case (csr_index)
            REG_BAND_COUNT: begin
               if (n_req == '0) begin
                  band_count_in = BCNT_W'(1);
               end else if (int'(n_req) > MAX_BANDS) begin
                  band_count_in = BCNT_W'(MAX_BANDS);
               end else begin
                  band_count_in = BCNT_W'(n_req);
               end
               for (int i = 0; i < MAX_BANDS; i++) begin
                  z1_in[i] = '0;
                  z2_in[i] = '0;
               end
            end
            REG_ENABLE: enable_in = csr_data[0];
            default: enable_in = enable_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_func == FUNC_SAMPLE)) begin
               if (!enable_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = req_sample_in;
                  rsp_blk_in    = req_block_end;
               end else begin
                  x_in     = req_sample_in;
                  blk_in   = req_block_end;
                  band_in  = '0;
                  phase_in = PH_MB0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            phase_in = phase_ff + 1'b1;
            case (phase_ff)
               PH_MB0: acc_in = acc_ff;
               PH_MB1: y_in = sat_sample($signed(ysum[SUM_W-1:DELAY_FRAC]));
               PH_MA1: acc_in = SUM_W'(prod_ff) + SUM_W'(z2_ff[band_ff]);
               PH_MB2: z1_in[band_ff] = sat_delay(acc_ff - SUM_W'(prod_ff));
               PH_MA2: acc_in = SUM_W'(prod_ff);
               PH_Z2: begin
                  z2_in[band_ff] = sat_delay(acc_ff - SUM_W'(prod_ff));
                  x_in           = y_ff;
                  phase_in       = PH_MB0;
                  if (BCNT_W'(band_ff) + BCNT_W'(1) == band_count_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     band_in = band_ff + 1'b1;
                  end
               end
               default: phase_in = PH_MB0;
            endcase
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = x_ff;
               rsp_blk_in    = blk_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_MB0;
         band_ff       <= '0;
         band_count_ff <= BCNT_W'(1);
         enable_ff     <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_BANDS; i++) begin
            z1_ff[i] <= '0;
            z2_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         band_ff       <= band_in;
         band_count_ff <= band_count_in;
         enable_ff     <= enable_in;
         rsp_valid_ff  <= rsp_valid_in;
         z1_ff         <= z1_in;
         z2_ff         <= z2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      blk_ff        <= blk_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_blk_ff    <= rsp_blk_in;
   end

   // checks
   `CBQ_ASSERT_HOLDS(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_ready, "req_ready high while a sample is being filtered")
   `CBQ_ASSERT_NEXT(a_coeff_wr_idle, clock, reset, req_acc && (req_func == FUNC_COEFF), state_ff == ST_IDLE, "coefficient write started filtering")
   `CBQ_ASSERT_HOLDS(a_band_in_range, clock, reset, state_ff == ST_RUN, BCNT_W'(band_ff) < band_count_ff, "band index beyond band count")
   `CBQ_ASSERT_NEXT(a_done_delivers, clock, reset, (state_ff == ST_DONE) && out_free, rsp_valid && (state_ff == ST_IDLE), "finished sample not loaded into output")

endmodule

/* verif/tb_top.sv */
// self-checking bench for the cascaded biquad equalizer: directed script, then random phases
// holds its own fixed-point cascade predictor; depends on cbq_pkg and the top level only
`timescale 1ns / 100ps

module tb_top
   import cbq_pkg::*;
();

   localparam int DRAIN_CYCLES    = 6 * MAX_BANDS + 2 + 16;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int NUM_PHASES      = 12;
   localparam int PHASE_SAMPLES   = 54;

   typedef enum {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      logic                       func;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       blk_end;
      logic [BSEL_W-1:0]          band;
      logic [SEL_W-1:0]           csel;
      logic signed [CVAL_W-1:0]   cval;
   } eq_req_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       block_end_out;
   } out_beat_type;

   typedef struct {
      row_kind_type               kind;
      logic [CSR_IDX_W-1:0]       reg_idx;
      logic [CSR_DATA_W-1:0]      reg_val;
      eq_req_type                 item;
      bit                         typed;
      logic signed [SAMPLE_W-1:0] typed_out;
   } script_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_func = FUNC_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       req_block_end = 1'b0;
   logic [BSEL_W-1:0]          req_band_sel = '0;
   logic [SEL_W-1:0]           req_coeff_sel = '0;
   logic signed [CVAL_W-1:0]   req_coeff_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_block_end_out;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // predictor state
   longint coeff_mem [NUM_ENTRIES] = '{default: 0};
   longint z_one [MAX_BANDS] = '{default: 0};
   longint z_two [MAX_BANDS] = '{default: 0};
   int     n_bands = 1;
   bit     filt_on = 1'b1;

   out_beat_type   due_samples [$];
   script_row_type script [$];
   int             n_errors = 0;
   int             send_idle_pct = 12;
   int             recv_idle_pct = 63;
   int             hold_reqs = 0;
   int             hold_done = 0;

   cascaded_biquad_equalizer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_sample_in     (req_sample_in),
      .req_block_end     (req_block_end),
      .req_band_sel      (req_band_sel),
      .req_coeff_sel     (req_coeff_sel),
      .req_coeff_value   (req_coeff_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_block_end_out (rsp_block_end_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_w(input longint v, input int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // floor(c * v / 2^16)
   function automatic longint qmul(input longint c, input longint v);
      return (c * v) >>> PROD_SHIFT;
   endfunction

   function automatic bit filter_beat(input eq_req_type it, output out_beat_type res);
      longint x, y, acc;
      int base;
      res.sample_out    = '0;
      res.block_end_out = 1'b0;
      if (it.func == FUNC_COEFF) begin
         if ((int'(it.band) < MAX_BANDS) && (int'(it.csel) < NUM_COEFFS))
            coeff_mem[it.band * NUM_COEFFS + it.csel] = longint'(it.cval);
         return 1'b0;
      end
      x = longint'(it.sample);
      if (filt_on) begin
         for (int b = 0; b < n_bands; b++) begin
            base = b * NUM_COEFFS;
            acc = qmul(coeff_mem[base + CSEL_B0], x) + z_one[b];
            y = clamp_w((acc + (longint'(1) <<< (DELAY_FRAC - 1))) >>> DELAY_FRAC, SAMPLE_W);
            z_one[b] = clamp_w(qmul(coeff_mem[base + CSEL_B1], x)
                               - qmul(coeff_mem[base + CSEL_A1], y) + z_two[b], DELAY_W);
            z_two[b] = clamp_w(qmul(coeff_mem[base + CSEL_B2], x)
                               - qmul(coeff_mem[base + CSEL_A2], y), DELAY_W);
            x = y;
         end
      end
      res.sample_out    = x[SAMPLE_W-1:0];
      res.block_end_out = it.blk_end;
      return 1'b1;
   endfunction

   function automatic script_row_type smp(input int s, input bit be, input bit typed,
                                          input int out);
      script_row_type r;
      r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0,
            item: '{FUNC_SAMPLE, SAMPLE_W'(s), be, '0, '0, '0},
            typed: typed, typed_out: SAMPLE_W'(out)};
      return r;
   endfunction

   function automatic script_row_type coef(input int band, input int sel, input int val);
      script_row_type r;
      r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0,
            item: '{FUNC_COEFF, 24'h5a5a5a, 1'b1, BSEL_W'(band), SEL_W'(sel), val},
            typed: 1'b0, typed_out: '0};
      return r;
   endfunction

   function automatic script_row_type regw(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] val);
      script_row_type r;
      r = '{kind: ROW_REG, reg_idx: idx, reg_val: val,
            item: '{FUNC_SAMPLE, '0, 1'b0, '0, '0, '0},
            typed: 1'b0, typed_out: '0};
      return r;
   endfunction

   // offers one beat and waits for it to be taken; entered and left at a rising edge
   task automatic push_item(input eq_req_type it, input bit typed,
                            input logic signed [SAMPLE_W-1:0] typed_out);
      out_beat_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= it.func;
      req_sample_in   <= it.sample;
      req_block_end   <= it.blk_end;
      req_band_sel    <= it.band;
      req_coeff_sel   <= it.csel;
      req_coeff_value <= it.cval;
      do @(posedge clock); while (!req_ready);
      if (filter_beat(it, res)) begin
         if (typed) res.sample_out = typed_out;
         due_samples.push_back(res);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (due_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_BAND_COUNT) begin
         n_bands = (val == 0) ? 1 : (val > MAX_BANDS) ? MAX_BANDS : int'(val);
         foreach (z_one[b]) begin
            z_one[b] = 0;
            z_two[b] = 0;
         end
      end else if (idx == REG_ENABLE) begin
         filt_on = val[0];
      end
      @(posedge clock);
   endtask

   // receiver: random back-pressure, plus long hold-offs on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_reqs != hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      out_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_samples.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual sample_out %0d block_end_out %0b",
                     $time, rsp_sample_out, rsp_block_end_out);
            n_errors++;
         end else begin
            want = due_samples.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $display("%0t sample_out mismatch: expected %0d actual %0d",
                        $time, want.sample_out, rsp_sample_out);
               n_errors++;
            end
            if (rsp_block_end_out !== want.block_end_out) begin
               $display("%0t block_end_out mismatch: expected %0b actual %0b",
                        $time, want.block_end_out, rsp_block_end_out);
               n_errors++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      eq_req_type it;
      logic [CSR_DATA_W-1:0] cval4;
      int bc_plan [NUM_PHASES];
      int r;
      int flavour;

      bc_plan = '{1, 8, 0, 15, 2, 8, 5, 1, 8, 3, 15, 4};

      // zero coefficients after reset, then unity b0 on band 0
      script.push_back(smp(8388607, 1'b0, 1'b1, 0));
      script.push_back(smp(-8388608, 1'b1, 1'b1, 0));
      script.push_back(coef(0, CSEL_B0, 32'h0100_0000));
      script.push_back(smp(8388607, 1'b1, 1'b1, 8388607));
      script.push_back(smp(-8388608, 1'b0, 1'b1, -8388608));
      // selector out of range, and an unused band
      script.push_back(coef(7, 5, 32'h7fff_ffff));
      script.push_back(coef(0, 7, 32'h8000_0000));
      script.push_back(coef(7, CSEL_B0, 32'h7fff_ffff));
      script.push_back(smp(4660, 1'b0, 1'b1, 4660));
      // band count clamped low and high
      script.push_back(regw(REG_BAND_COUNT, 4'd0));
      script.push_back(smp(-1, 1'b1, 1'b1, -1));
      script.push_back(regw(REG_BAND_COUNT, 4'd15));
      script.push_back(smp(8388607, 1'b0, 1'b1, 0));
      // bypass
      script.push_back(regw(REG_ENABLE, 4'b1110));
      script.push_back(smp(-8388608, 1'b1, 1'b1, -8388608));
      script.push_back(smp(1234, 1'b0, 1'b1, 1234));
      script.push_back(regw(REG_ENABLE, 4'b0001));
      script.push_back(regw(REG_BAND_COUNT, 4'd1));
      // extreme coefficients drive the delay words into saturation
      script.push_back(coef(0, CSEL_B1, 32'h7fff_ffff));
      script.push_back(coef(0, CSEL_B2, 32'h8000_0000));
      script.push_back(coef(0, CSEL_A1, 32'h8000_0000));
      script.push_back(coef(0, CSEL_A2, 32'h7fff_ffff));
      script.push_back(smp(8388607, 1'b0, 1'b0, 0));
      script.push_back(smp(-8388608, 1'b1, 1'b0, 0));
      script.push_back(smp(8388607, 1'b0, 1'b0, 0));
      script.push_back(smp(0, 1'b1, 1'b0, 0));
      script.push_back(regw(REG_BAND_COUNT, 4'd8));
      script.push_back(smp(-8388608, 1'b0, 1'b0, 0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_REG) begin
            settle();
            write_reg(script[i].reg_idx, script[i].reg_val);
         end else begin
            push_item(script[i].item, script[i].typed, script[i].typed_out);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = (ph < 4) ? 12 : (ph < 8) ? 63 : 0;
         recv_idle_pct = (ph < 4) ? 63 : (ph < 8) ? 12 : 0;
         flavour = ph % 3;
         settle();
         write_reg(REG_BAND_COUNT, (ph == 6 || ph == 7) ? 4'($urandom_range(15)) : 4'(bc_plan[ph]));
         cval4 = 4'($urandom);
         cval4[0] = !(ph == 5 || ph == 10);
         write_reg(REG_ENABLE, cval4);

         for (int b = 0; b < MAX_BANDS; b++) begin
            for (int s = 0; s < NUM_COEFFS; s++) begin
               if ($urandom_range(1) == 1) begin
                  it = '{FUNC_COEFF, SAMPLE_W'($urandom), 1'($urandom_range(1)),
                         BSEL_W'(b), SEL_W'(s), '0};
                  case (flavour)
                     0: begin
                        if (s == CSEL_B0) it.cval = 32'h0080_0000 + $urandom_range(32'h0100_0000);
                        else it.cval = int'($urandom_range(32'h0080_0000)) - 32'h0040_0000;
                     end
                     1: it.cval = int'($urandom_range(32'h0800_0000)) - 32'h0400_0000;
                     default: it.cval = $urandom;
                  endcase
                  push_item(it, 1'b0, '0);
               end
            end
         end

         if (ph == 1 || ph == 9) hold_reqs++;

         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if ($urandom_range(99) < 6) begin
               it = '{FUNC_COEFF, SAMPLE_W'($urandom), 1'($urandom_range(1)),
                      BSEL_W'($urandom), SEL_W'($urandom), $urandom};
               push_item(it, 1'b0, '0);
            end
            r = $urandom_range(99);
            it = '{FUNC_SAMPLE, '0, 1'($urandom_range(1)),
                   BSEL_W'($urandom), SEL_W'($urandom), $urandom};
            if (r < 70) it.sample = SAMPLE_W'($urandom);
            else if (r < 90) it.sample = SAMPLE_W'(int'($urandom_range(2000)) - 1000);
            else it.sample = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            push_item(it, 1'b0, '0);
         end
      end

      settle();
      if (n_errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
